### sv/bcvc_pkg.sv
package bcvc_pkg;

    localparam int FIELD_WIDTH     = 16;
    localparam int HALF_WIDTH      = 16;
    localparam int REG_WIDTH       = 32;
    localparam int NUM_REGS        = 8;
    localparam int CFG_ADDR_WIDTH  = 4;
    localparam int NUM_AXES        = 3;
    localparam int NUM_ROWS        = 4;
    localparam int NUM_CORNERS     = 8;
    localparam int NUM_PLANES      = 6;
    localparam int W_ONE_SHIFT     = 4;
    localparam int SUM_GROWTH      = 2;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF  = 16;

    // clip rows
    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_Z = 2;
    localparam int ROW_W = 3;

    // outcode bits
    localparam int PLANE_LEFT   = 0;
    localparam int PLANE_RIGHT  = 1;
    localparam int PLANE_BOTTOM = 2;
    localparam int PLANE_TOP    = 3;
    localparam int PLANE_NEAR   = 4;
    localparam int PLANE_FAR    = 5;

    // identity view-projection after reset
    localparam logic [REG_WIDTH-1:0] REG_RESET [NUM_REGS] = '{
        32'h0000_1000, 32'h0000_0000, 32'h1000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_1000, 32'h0000_0000, 32'h1000_0000
    };

    typedef struct packed {
        logic sum_en;
        logic code_en;
    } lane_ctl_t;

    // a coordinate width beyond the field sees the field zero-extended,
    // one extra bit keeps that value positive
    function automatic int coord_eff(input int w);
        return (w <= FIELD_WIDTH) ? w : FIELD_WIDTH + 1;
    endfunction

    function automatic int coef_eff(input int w);
        return (w < HALF_WIDTH) ? w : HALF_WIDTH;
    endfunction

    function automatic int prod_width(input int cw, input int kw);
        return coord_eff(cw) + coef_eff(kw);
    endfunction

endpackage

### sv/bcvc_prod.sv
module bcvc_prod #(
    parameter int COORD_WIDTH = bcvc_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = bcvc_pkg::COEF_WIDTH_DEF
) (
    input  logic clk,
    input  logic en,
    input  logic [bcvc_pkg::REG_WIDTH-1:0]   regs [bcvc_pkg::NUM_REGS],
    input  logic [bcvc_pkg::FIELD_WIDTH-1:0] lo   [bcvc_pkg::NUM_AXES],
    input  logic [bcvc_pkg::FIELD_WIDTH-1:0] hi   [bcvc_pkg::NUM_AXES],
    output logic signed [bcvc_pkg::prod_width(COORD_WIDTH, COEF_WIDTH)-1:0]
        prod_lo [bcvc_pkg::NUM_ROWS][bcvc_pkg::NUM_AXES],
    output logic signed [bcvc_pkg::prod_width(COORD_WIDTH, COEF_WIDTH)-1:0]
        prod_hi [bcvc_pkg::NUM_ROWS][bcvc_pkg::NUM_AXES],
    output logic signed [bcvc_pkg::prod_width(COORD_WIDTH, COEF_WIDTH)-1:0]
        trans   [bcvc_pkg::NUM_ROWS]
);
    import bcvc_pkg::*;

    localparam int CWE = coord_eff(COORD_WIDTH);
    localparam int KWE = coef_eff(COEF_WIDTH);
    localparam int PW  = CWE + KWE;
    localparam int TPAD = PW - KWE - W_ONE_SHIFT;

    logic signed [PW-1:0] prod_lo_reg [NUM_ROWS][NUM_AXES];
    logic signed [PW-1:0] prod_hi_reg [NUM_ROWS][NUM_AXES];
    logic signed [PW-1:0] trans_reg   [NUM_ROWS];

    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
        logic signed [KWE-1:0] k [NUM_AXES + 1];
        logic signed [PW-1:0]  trans_next;

        // coefficient col lives in register row*2 + col/2, half col%2
        for (genvar c = 0; c <= NUM_AXES; c++) begin : g_coef
            localparam int RI = r * 2 + c / 2;
            localparam int HI = (c % 2) * HALF_WIDTH;
            assign k[c] = regs[RI][HI +: KWE];
        end

        for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
            logic [FIELD_WIDTH:0]  lo_ext;
            logic [FIELD_WIDTH:0]  hi_ext;
            logic signed [CWE-1:0] clo;
            logic signed [CWE-1:0] chi;
            logic signed [PW-1:0]  plo_next;
            logic signed [PW-1:0]  phi_next;

            assign lo_ext   = {1'b0, lo[a]};
            assign hi_ext   = {1'b0, hi[a]};
            assign clo      = lo_ext[CWE-1:0];
            assign chi      = hi_ext[CWE-1:0];
            assign plo_next = k[a] * clo;
            assign phi_next = k[a] * chi;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_lo_reg[r][a] <= plo_next;
                    prod_hi_reg[r][a] <= phi_next;
                end
            end

            assign prod_lo[r][a] = prod_lo_reg[r][a];
            assign prod_hi[r][a] = prod_hi_reg[r][a];
        end

        // translation times w = 16 is a shift
        assign trans_next = {{TPAD{k[NUM_AXES][KWE-1]}}, k[NUM_AXES],
                             {W_ONE_SHIFT{1'b0}}};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                trans_reg[r] <= trans_next;
            end
        end

        assign trans[r] = trans_reg[r];
    end

endmodule

### sv/bcvc_lane.sv
module bcvc_lane #(
    parameter int COORD_WIDTH = bcvc_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = bcvc_pkg::COEF_WIDTH_DEF,
    parameter int CORNER      = 0
) (
    input  logic clk,
    input  bcvc_pkg::lane_ctl_t ctl,
    input  logic signed [bcvc_pkg::prod_width(COORD_WIDTH, COEF_WIDTH)-1:0]
        prod_lo [bcvc_pkg::NUM_ROWS][bcvc_pkg::NUM_AXES],
    input  logic signed [bcvc_pkg::prod_width(COORD_WIDTH, COEF_WIDTH)-1:0]
        prod_hi [bcvc_pkg::NUM_ROWS][bcvc_pkg::NUM_AXES],
    input  logic signed [bcvc_pkg::prod_width(COORD_WIDTH, COEF_WIDTH)-1:0]
        trans   [bcvc_pkg::NUM_ROWS],
    output logic [bcvc_pkg::NUM_PLANES-1:0] code
);
    import bcvc_pkg::*;

    localparam int PW  = prod_width(COORD_WIDTH, COEF_WIDTH);
    localparam int CLW = PW + SUM_GROWTH;

    logic signed [CLW-1:0]        clip_reg [NUM_ROWS];
    logic [NUM_PLANES-1:0]        code_reg;
    logic [NUM_PLANES-1:0]        code_next;

    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
        logic signed [CLW-1:0] term [NUM_AXES + 1];
        logic signed [CLW-1:0] clip_next;

        // corner bit per axis picks max over min
        for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
            localparam bit USE_HI = ((CORNER >> a) & 1) != 0;
            if (USE_HI) begin : g_hi
                assign term[a] = {{SUM_GROWTH{prod_hi[r][a][PW-1]}}, prod_hi[r][a]};
            end else begin : g_lo
                assign term[a] = {{SUM_GROWTH{prod_lo[r][a][PW-1]}}, prod_lo[r][a]};
            end
        end
        assign term[NUM_AXES] = {{SUM_GROWTH{trans[r][PW-1]}}, trans[r]};
        assign clip_next      = term[0] + term[1] + term[2] + term[NUM_AXES];

        always_ff @(posedge clk)
        begin
            if (ctl.sum_en)
            begin
                clip_reg[r] <= clip_next;
            end
        end
    end

    logic signed [CLW:0] x_plus_w;
    logic signed [CLW:0] y_plus_w;

    assign x_plus_w = {clip_reg[ROW_X][CLW-1], clip_reg[ROW_X]}
                    + {clip_reg[ROW_W][CLW-1], clip_reg[ROW_W]};
    assign y_plus_w = {clip_reg[ROW_Y][CLW-1], clip_reg[ROW_Y]}
                    + {clip_reg[ROW_W][CLW-1], clip_reg[ROW_W]};

    always_comb
    begin
        code_next              = '0;
        code_next[PLANE_LEFT]  = x_plus_w[CLW];
        code_next[PLANE_RIGHT] = clip_reg[ROW_X] > clip_reg[ROW_W];
        code_next[PLANE_BOTTOM]= y_plus_w[CLW];
        code_next[PLANE_TOP]   = clip_reg[ROW_Y] > clip_reg[ROW_W];
        code_next[PLANE_NEAR]  = clip_reg[ROW_Z][CLW-1];
        code_next[PLANE_FAR]   = clip_reg[ROW_Z] > clip_reg[ROW_W];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.code_en)
        begin
            code_reg <= code_next;
        end
    end

    assign code = code_reg;

endmodule

### sv/bcvc_merge.sv
module bcvc_merge (
    input  logic clk,
    input  logic en,
    input  logic invalid,
    input  logic [bcvc_pkg::NUM_PLANES-1:0] code [bcvc_pkg::NUM_CORNERS],
    output logic visible,
    output logic [bcvc_pkg::NUM_PLANES-1:0] mask
);
    import bcvc_pkg::*;

    logic [NUM_PLANES-1:0] mask_reg;
    logic [NUM_PLANES-1:0] mask_next;
    logic                  visible_reg;

    always_comb
    begin
        mask_next = '1;
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            mask_next = mask_next & code[i];
        end
        // a box with min above max is reported visible with no planes
        if (invalid)
        begin
            mask_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mask_reg    <= mask_next;
            visible_reg <= (mask_next == '0);
        end
    end

    assign mask    = mask_reg;
    assign visible = visible_reg;

endmodule

### sv/box_clip_volume_cull.sv
// box against clip volume cull, eight corner lanes plus an and-merge stage
// path from the input transfer to the result on m_tvalid: one register stage each
//   for products, clip sums, outcodes and merge
// throughput: one box per cycle; each stage stalls only when its successor is full
// reset: rst_n asynchronous active low clears all stage valids and loads the
//   identity matrix into the eight coefficient registers
module box_clip_volume_cull #(
    parameter int COORD_WIDTH = bcvc_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = bcvc_pkg::COEF_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [bcvc_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [bcvc_pkg::REG_WIDTH-1:0]      cfg_wdata,
    // box in
    input  logic         s_tvalid,
    output logic         s_tready,
    // min_x [15:0], min_y [31:16], min_z [47:32], max_x [63:48], max_y [79:64],
    // max_z [95:80]
    input  logic [95:0]  s_tdata,
    // cull result out
    output logic         m_tvalid,
    input  logic         m_tready,
    // visible [0], common_outside_mask [6:1], zero pad [7]
    output logic [7:0]   m_tdata
);
    import bcvc_pkg::*;

    localparam int CWE = coord_eff(COORD_WIDTH);
    localparam int PW  = prod_width(COORD_WIDTH, COEF_WIDTH);

    // coefficient registers
    logic [REG_WIDTH-1:0] regs_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= REG_RESET[i];
            end
        end
        else if (cfg_we && (cfg_addr < CFG_ADDR_WIDTH'(NUM_REGS)))
        begin
            // writes beyond the register list are dropped
            regs_reg[cfg_addr[$clog2(NUM_REGS)-1:0]] <= cfg_wdata;
        end
    end

    // pipeline control: a stage takes new data when it is empty or drains
    logic valid_prod_reg;
    logic valid_sum_reg;
    logic valid_code_reg;
    logic valid_out_reg;
    logic ready_prod;
    logic ready_sum;
    logic ready_code;
    logic ready_out;
    lane_ctl_t lane_ctl;

    assign ready_out  = !valid_out_reg  || m_tready;
    assign ready_code = !valid_code_reg || ready_out;
    assign ready_sum  = !valid_sum_reg  || ready_code;
    assign ready_prod = !valid_prod_reg || ready_sum;

    assign lane_ctl.sum_en  = ready_sum;
    assign lane_ctl.code_en = ready_code;

    assign s_tready = ready_prod;
    assign m_tvalid = valid_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_prod_reg <= 1'b0;
            valid_sum_reg  <= 1'b0;
            valid_code_reg <= 1'b0;
            valid_out_reg  <= 1'b0;
        end
        else
        begin
            if (ready_prod)
            begin
                valid_prod_reg <= s_tvalid;
            end
            if (ready_sum)
            begin
                valid_sum_reg <= valid_prod_reg;
            end
            if (ready_code)
            begin
                valid_code_reg <= valid_sum_reg;
            end
            if (ready_out)
            begin
                valid_out_reg <= valid_code_reg;
            end
        end
    end

    // unpack box corners
    logic [FIELD_WIDTH-1:0] box_lo [NUM_AXES];
    logic [FIELD_WIDTH-1:0] box_hi [NUM_AXES];
    logic [NUM_AXES-1:0]    axis_bad;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_unpack
        logic [FIELD_WIDTH:0]  lo_ext;
        logic [FIELD_WIDTH:0]  hi_ext;
        logic signed [CWE-1:0] lo_s;
        logic signed [CWE-1:0] hi_s;

        assign box_lo[a]   = s_tdata[a * FIELD_WIDTH +: FIELD_WIDTH];
        assign box_hi[a]   = s_tdata[(a + NUM_AXES) * FIELD_WIDTH +: FIELD_WIDTH];
        // a coordinate wider than the field reads the field as unsigned
        assign lo_ext      = {1'b0, box_lo[a]};
        assign hi_ext      = {1'b0, box_hi[a]};
        assign lo_s        = lo_ext[CWE-1:0];
        assign hi_s        = hi_ext[CWE-1:0];
        assign axis_bad[a] = lo_s > hi_s;
    end

    // invalid-box flag rides alongside the lanes
    logic invalid_prod_reg;
    logic invalid_sum_reg;
    logic invalid_code_reg;

    always_ff @(posedge clk)
    begin
        if (ready_prod)
        begin
            invalid_prod_reg <= |axis_bad;
        end
        if (ready_sum)
        begin
            invalid_sum_reg <= invalid_prod_reg;
        end
        if (ready_code)
        begin
            invalid_code_reg <= invalid_sum_reg;
        end
    end

    // shared product stage: every axis coefficient times both min and max of its axis, translation shifted
    logic signed [PW-1:0] prod_lo [NUM_ROWS][NUM_AXES];
    logic signed [PW-1:0] prod_hi [NUM_ROWS][NUM_AXES];
    logic signed [PW-1:0] trans   [NUM_ROWS];

    bcvc_prod #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_prod (
        .clk     (clk),
        .en      (ready_prod),
        .regs    (regs_reg),
        .lo      (box_lo),
        .hi      (box_hi),
        .prod_lo (prod_lo),
        .prod_hi (prod_hi),
        .trans   (trans)
    );

    // one lane per corner: clip sums, then outcode
    logic [NUM_PLANES-1:0] corner_code [NUM_CORNERS];

    for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_lane
        bcvc_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .COEF_WIDTH  (COEF_WIDTH),
            .CORNER      (c)
        ) u_lane (
            .clk     (clk),
            .ctl     (lane_ctl),
            .prod_lo (prod_lo),
            .prod_hi (prod_hi),
            .trans   (trans),
            .code    (corner_code[c])
        );
    end

    // and of all outcodes, cleared for an invalid box, registered as the output stage
    logic                  res_visible;
    logic [NUM_PLANES-1:0] res_mask;

    bcvc_merge u_merge (
        .clk     (clk),
        .en      (ready_out),
        .invalid (invalid_code_reg),
        .code    (corner_code),
        .visible (res_visible),
        .mask    (res_mask)
    );

    assign m_tdata = {1'b0, res_mask, res_visible};

`ifndef SYNTHESIS
    // visible is exactly the absence of a common outside plane
    a_visible_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[6:1] == '0)))
        else $error("visible disagrees with outside mask");

    // an invalid box leaves the merge with an empty mask
    a_invalid_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (ready_out && valid_code_reg && invalid_code_reg) |=> (m_tdata[6:1] == '0))
        else $error("invalid box produced a nonzero mask");

    // a free output never backs up the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is free");

    // an accepted config write lands in its register
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_addr < CFG_ADDR_WIDTH'(NUM_REGS)))
        |=> (regs_reg[$past(cfg_addr[$clog2(NUM_REGS)-1:0])] == $past(cfg_wdata)))
        else $error("config write lost");
`endif

endmodule
